FILE: rtl/cal_pkg.sv
// cal_pkg: shared types, constants and helper functions for the calendar day counter.
// Used by cal_advance and calendar_day_counter. Depends on nothing else.
`timescale 1ns / 1ps

package cal_pkg;

    // Calendar limits
    localparam logic [13:0] BASE_YEAR      = 14'd1922;
    localparam logic [13:0] START_YEAR_MAX = 14'd2100;
    localparam logic [13:0] TOP_YEAR       = 14'd9999;
    localparam logic [13:0] YEAR_1900      = 14'd1900;
    localparam logic [13:0] YEAR_2000      = 14'd2000;
    localparam logic [2:0]  BASE_WEEKDAY   = 3'd7;   // 1922-01-01 was a Sunday
    localparam logic [2:0]  WD_MONDAY      = 3'd1;
    localparam logic [2:0]  WD_SUNDAY      = 3'd7;
    localparam logic [3:0]  MONTH_JAN      = 4'd1;
    localparam logic [3:0]  MONTH_DEC      = 4'd12;
    localparam logic [4:0]  DAY_FIRST      = 5'd1;
    localparam logic [4:0]  DAY_LAST_DEC   = 5'd31;
    localparam logic [6:0]  Y100_LAST      = 7'd99;

    // Configuration register indexes
    typedef enum logic {
        CFG_START_YEAR = 1'b0,
        CFG_LAST_YEAR  = 1'b1
    } t_cfg_idx;

    // Date state; y100 is year mod 100, c4 is (year / 100) mod 4
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [6:0]  y100;
        logic [1:0]  c4;
    } t_date;

    // Gregorian leap rule from the running residues
    function automatic logic is_leap(input logic [6:0] y100, input logic [1:0] c4,
                                     input logic [1:0] ylo);
        if (y100 == 7'd0) begin
            return (c4 == 2'd0);
        end
        return (ylo == 2'd0);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
            4'd2:                    month_len = leap ? 5'd29 : 5'd28;
            default:                 month_len = 5'd31;
        endcase
    endfunction

    // x mod 7 by folding octal digits (8 = 1 mod 7)
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        s1 = {1'b0, x[7:3]} + {3'b0, x[2:0]};
        s2 = {1'b0, s1[5:3]} + {1'b0, s1[2:0]};
        if (s2 >= 4'd7) begin
            s2 = s2 - 4'd7;
        end
        return s2[2:0];
    endfunction

endpackage

FILE: rtl/cal_advance.sv
// cal_advance: next-date logic for one day tick (restart load, advance, hold at top).
// Depends on cal_pkg for the date struct and leap / month-length helpers.
`timescale 1ns / 1ps

module cal_advance
    import cal_pkg::*;
(
    input  t_date       i_cur,
    input  t_date       i_ld,
    input  logic        i_restart,
    input  logic [13:0] i_last_year,
    output t_date       o_nxt,
    output logic        o_leap,
    output logic        o_range_end
);

    logic       leap_cur;
    logic       at_top;
    logic [4:0] mlen;

    always_comb begin
        leap_cur = is_leap(i_cur.y100, i_cur.c4, i_cur.year[1:0]);
        mlen     = month_len(i_cur.month, leap_cur);
        at_top   = (i_cur.year >= TOP_YEAR) && (i_cur.month == MONTH_DEC) &&
                   (i_cur.day == DAY_LAST_DEC);
        o_nxt    = i_cur;

        if (i_restart) begin
            o_nxt = i_ld;
        end else if (!at_top) begin
            if (i_cur.day >= mlen) begin
                o_nxt.day = DAY_FIRST;
                if (i_cur.month >= MONTH_DEC) begin
                    o_nxt.month = MONTH_JAN;
                    o_nxt.year  = i_cur.year + 14'd1;
                    if (i_cur.y100 == Y100_LAST) begin
                        o_nxt.y100 = 7'd0;
                        o_nxt.c4   = i_cur.c4 + 2'd1;
                    end else begin
                        o_nxt.y100 = i_cur.y100 + 7'd1;
                    end
                end else begin
                    o_nxt.month = i_cur.month + 4'd1;
                end
            end else begin
                o_nxt.day = i_cur.day + 5'd1;
            end
            o_nxt.weekday = (i_cur.weekday >= WD_SUNDAY) ? WD_MONDAY
                                                         : i_cur.weekday + 3'd1;
        end

        o_leap      = is_leap(o_nxt.y100, o_nxt.c4, o_nxt.year[1:0]);
        o_range_end = (o_nxt.year == i_last_year) && (o_nxt.month == MONTH_DEC) &&
                      (o_nxt.day == DAY_LAST_DEC);
    end

endmodule

FILE: rtl/calendar_day_counter.sv
// calendar_day_counter: Gregorian day counter, one date per day-tick beat.
// The date of an accepted beat is registered directly into the output registers.
// Throughput: 1 beat per cycle when not stalled; a new beat is taken while the last date is drained.
// Reset (synchronous, active low): date 1922-01-01, Sunday; start_year and
// last_year both 1922; output empty.
`timescale 1ns / 1ps

module calendar_day_counter
    import cal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // day-tick channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_restart,
    // date channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [13:0] o_out_year,
    output logic [3:0]  o_out_month,
    output logic [4:0]  o_out_day,
    output logic [2:0]  o_out_weekday,
    output logic        o_leap_flag,
    output logic        o_range_end,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [13:0] i_cfg_data
);

    // The date registers double as the output payload: they only move when a
    // beat is accepted, and a beat is only accepted when the held date is
    // either absent or leaving this same edge.
    t_date       r_date,  n_date;
    t_date       r_ld,    n_ld;       // restart target, prepared at config write
    logic [13:0] r_last_year;
    logic        r_out_valid;
    logic        r_leap,  n_leap;
    logic        r_range_end, n_range_end;

    logic        in_acc;
    logic        cfg_wr;

    // restart preload datapath
    logic [11:0] cfg_sy;
    logic [13:0] yc;
    logic [7:0]  diff;
    logic [7:0]  leaps;
    logic [7:0]  wd_sum;

    assign o_stall     = r_out_valid & i_stall;
    assign in_acc      = i_valid & ~o_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    // Jan 1 weekday of the clamped start year: 365 = 1 and 366 = 2 mod 7, so
    // the day count mod 7 is (years + leap years) mod 7, base Sunday.
    always_comb begin
        cfg_sy = i_cfg_data[11:0];
        yc     = {2'b00, cfg_sy};
        if (yc < BASE_YEAR) begin
            yc = BASE_YEAR;
        end else if (yc > START_YEAR_MAX) begin
            yc = START_YEAR_MAX;
        end
        diff   = 8'(yc - BASE_YEAR);
        leaps  = (diff + 8'd1) >> 2;
        wd_sum = diff + leaps + 8'(BASE_WEEKDAY - 3'd1);

        n_ld.year    = yc;
        n_ld.month   = MONTH_JAN;
        n_ld.day     = DAY_FIRST;
        n_ld.weekday = mod7(wd_sum) + 3'd1;
        if (yc < YEAR_2000) begin
            n_ld.y100 = 7'(yc - YEAR_1900);
            n_ld.c4   = 2'd3;
        end else if (yc < START_YEAR_MAX) begin
            n_ld.y100 = 7'(yc - YEAR_2000);
            n_ld.c4   = 2'd0;
        end else begin
            n_ld.y100 = 7'd0;
            n_ld.c4   = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld.year    <= BASE_YEAR;
            r_ld.month   <= MONTH_JAN;
            r_ld.day     <= DAY_FIRST;
            r_ld.weekday <= BASE_WEEKDAY;
            r_ld.y100    <= 7'd22;
            r_ld.c4      <= 2'd3;
            r_last_year  <= BASE_YEAR;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                CFG_START_YEAR: r_ld        <= n_ld;
                CFG_LAST_YEAR:  r_last_year <= i_cfg_data;
                default:        r_last_year <= r_last_year;
            endcase
        end
    end

    cal_advance u_adv (
        .i_cur       (r_date),
        .i_ld        (r_ld),
        .i_restart   (i_restart),
        .i_last_year (r_last_year),
        .o_nxt       (n_date),
        .o_leap      (n_leap),
        .o_range_end (n_range_end)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_date.year    <= BASE_YEAR;
            r_date.month   <= MONTH_JAN;
            r_date.day     <= DAY_FIRST;
            r_date.weekday <= BASE_WEEKDAY;
            r_date.y100    <= 7'd22;
            r_date.c4      <= 2'd3;
            r_out_valid    <= 1'b0;
            r_leap         <= 1'b0;
            r_range_end    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_date      <= n_date;
                r_leap      <= n_leap;
                r_range_end <= n_range_end;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_year    = r_date.year;
    assign o_out_month   = r_date.month;
    assign o_out_day     = r_date.day;
    assign o_out_weekday = r_date.weekday;
    assign o_leap_flag   = r_leap;
    assign o_range_end   = r_range_end;

    // ---------------------------------------------------------------- checks
    a_date_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_month >= MONTH_JAN) && (o_out_month <= MONTH_DEC) &&
        (o_out_day >= DAY_FIRST) && (o_out_day <= DAY_LAST_DEC))
        else $error("date register out of range");

    a_restart_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_restart) |=>
        (o_out_month == MONTH_JAN) && (o_out_day == DAY_FIRST) &&
        (o_out_year == $past(r_ld.year)) && (o_out_weekday == $past(r_ld.weekday)))
        else $error("restart did not load January 1 of start year");

    a_weekday_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_restart && (o_out_year < TOP_YEAR)) |=>
        (o_out_weekday == (($past(o_out_weekday) == WD_SUNDAY) ? WD_MONDAY
                                                             : $past(o_out_weekday) + 3'd1)))
        else $error("weekday did not advance by one");

    a_range_end_dec31: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_range_end) |->
        (o_out_month == MONTH_DEC) && (o_out_day == DAY_LAST_DEC) &&
        (o_out_year == r_last_year))
        else $error("range end flagged away from December 31 of last year");

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking testbench for calendar_day_counter.
// Holds its own calendar predictor and a queue of expected dates; needs cal_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import cal_pkg::*;

    // cycles with no accepted beat on any channel before the run is abandoned
    localparam int WATCHDOG_LIMIT = 4000;
    // cycles waited out once the queue is empty, before the final verdict
    localparam int TAIL_CYCLES    = 4;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic        leap;
        logic        range_end;
    } t_date_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_restart;
    logic        o_valid;
    logic        i_stall;
    logic [13:0] o_out_year;
    logic [3:0]  o_out_month;
    logic [4:0]  o_out_day;
    logic [2:0]  o_out_weekday;
    logic        o_leap_flag;
    logic        o_range_end;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [13:0] i_cfg_data;

    calendar_day_counter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_restart     (i_restart),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_year    (o_out_year),
        .o_out_month   (o_out_month),
        .o_out_day     (o_out_day),
        .o_out_weekday (o_out_weekday),
        .o_leap_flag   (o_leap_flag),
        .o_range_end   (o_range_end),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Predictor state: running date plus a copy of both registers
    logic [13:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [2:0]  cal_weekday;
    logic [11:0] cfg_start;
    logic [13:0] cfg_last;

    t_date_beat  pending_dates[$];
    int          mismatch_count;
    bit          sender_calm;

    function automatic bit greg_leap(input int unsigned y);
        if (y % 100 == 0) begin
            return (y % 400) == 0;
        end
        return (y % 4) == 0;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        if (m == 2) begin
            return greg_leap(y) ? 29 : 28;
        end
        return 31;
    endfunction

    // Jan 1 weekday by the simple every-fourth-year count from 1922, a Sunday
    function automatic logic [2:0] new_year_weekday(input int unsigned y);
        int unsigned span;
        int unsigned leaps;
        int unsigned days;
        span  = y - BASE_YEAR;
        leaps = (span + 1) / 4;
        days  = 365 * (span - leaps) + 366 * leaps;
        return 3'(((BASE_WEEKDAY - 1 + days) % 7) + 1);
    endfunction

    // Steps the predicted calendar by one accepted tick and queues the date
    task automatic predict_tick(input bit restart);
        t_date_beat  d;
        int unsigned y;
        if (restart) begin
            y = cfg_start;
            if (y < BASE_YEAR) begin
                y = BASE_YEAR;
            end
            if (y > START_YEAR_MAX) begin
                y = START_YEAR_MAX;
            end
            cal_year    = 14'(y);
            cal_month   = MONTH_JAN;
            cal_day     = DAY_FIRST;
            cal_weekday = new_year_weekday(y);
        end else if (!(cal_year >= TOP_YEAR && cal_month == MONTH_DEC &&
                       cal_day == DAY_LAST_DEC)) begin
            if (cal_day >= days_in_month(cal_month, cal_year)) begin
                cal_day = DAY_FIRST;
                if (cal_month >= MONTH_DEC) begin
                    cal_month = MONTH_JAN;
                    cal_year  = cal_year + 14'd1;
                end else begin
                    cal_month = cal_month + 4'd1;
                end
            end else begin
                cal_day = cal_day + 5'd1;
            end
            cal_weekday = (cal_weekday >= WD_SUNDAY) ? WD_MONDAY : cal_weekday + 3'd1;
        end
        d.year      = cal_year;
        d.month     = cal_month;
        d.day       = cal_day;
        d.weekday   = cal_weekday;
        d.leap      = greg_leap(cal_year);
        d.range_end = (cal_year == cfg_last && cal_month == MONTH_DEC &&
                       cal_day == DAY_LAST_DEC);
        pending_dates.push_back(d);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // mostly back-to-back, some short gaps, the odd long one
    function automatic int pick_gap();
        int r;
        if (sender_calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge; leaves valid high unless a gap follows
    task automatic send_tick(input bit restart);
        int gap;
        i_valid   <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (o_stall);
        predict_tick(restart);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid   <= 1'b0;
            i_restart <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Sender holds off until every queued date has come out
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_dates.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [13:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_START_YEAR) begin
            cfg_start = data[11:0];
        end else begin
            cfg_last = data;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 14'($urandom_range(0, 16383));
    endtask

    // Random ticks; restarts come about once in restart_odds beats
    task automatic run_ticks(input int count, input int restart_odds);
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                sender_calm = ($urandom_range(0, 3) == 0);
            end
            send_tick($urandom_range(0, restart_odds - 1) == 0);
        end
        sender_calm = 1'b0;
    endtask

    // ---- directed tests ----

    task automatic test_reset_date();
        // advance from the reset date, then reload Jan 1 of the reset start year
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic test_start_year_clamp();
        // below range, range edges, above range, upper bits beyond the register
        write_reg(CFG_START_YEAR, 14'd0);
        send_tick(1'b1);
        write_reg(CFG_START_YEAR, 14'd1921);
        send_tick(1'b1);
        write_reg(CFG_START_YEAR, 14'd2100);
        send_tick(1'b1);
        send_tick(1'b0);
        write_reg(CFG_START_YEAR, 14'd2101);
        send_tick(1'b1);
        write_reg(CFG_START_YEAR, 14'h3FFF);
        send_tick(1'b1);
        write_reg(CFG_START_YEAR, 14'd2000);
        send_tick(1'b1);
        send_tick(1'b0);
        write_reg(CFG_START_YEAR, 14'd1922);
        send_tick(1'b1);
    endtask

    task automatic test_last_year_extremes();
        // values no date reaches in this test leave range_end low
        write_reg(CFG_LAST_YEAR, 14'd0);
        send_tick(1'b0);
        send_tick(1'b1);
        write_reg(CFG_LAST_YEAR, 14'h3FFF);
        send_tick(1'b0);
        write_reg(CFG_LAST_YEAR, 14'd9999);
        send_tick(1'b0);
    endtask

    task automatic test_drain_pause();
        sender_calm = 1'b1;
        repeat (4) send_tick(1'b0);
        sender_calm = 1'b0;
        drain_results();
        repeat (2) send_tick(1'b0);
    endtask

    // ---- random tests ----

    task automatic test_year_end_2100();
        // non-leap century year; walks past Dec 31 into 2101
        write_reg(CFG_START_YEAR, 14'd2100);
        write_reg(CFG_LAST_YEAR, 14'd2100);
        send_tick(1'b1);
        run_ticks(370, 512);
    endtask

    task automatic test_leap_year_span();
        int unsigned y;
        if ($urandom_range(0, 1) == 1) begin
            y = 1924 + 4 * $urandom_range(0, 43);
        end else begin
            y = $urandom_range(1922, 2100);
        end
        write_reg(CFG_START_YEAR, 14'(y));
        write_reg(CFG_LAST_YEAR, 14'(y));
        send_tick(1'b1);
        run_ticks(370, 512);
    endtask

    task automatic test_random_configs();
        logic [13:0] s;
        logic [13:0] l;
        for (int k = 0; k < 4; k++) begin
            s = ($urandom_range(0, 1) == 1) ? 14'($urandom_range(1922, 2100))
                                           : 14'($urandom_range(0, 16383));
            l = ($urandom_range(0, 1) == 1) ? s : 14'($urandom_range(0, 16383));
            write_reg(CFG_START_YEAR, s);
            write_reg(CFG_LAST_YEAR, l);
            run_ticks(50, 8);
        end
    endtask

    // ---- result checker: one beat per accepted output ----
    always @(posedge i_clk) begin
        t_date_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_dates.size() == 0) begin
                $error("out_year: expected none, got %0d", o_out_year);
                mismatch_count++;
            end else begin
                want = pending_dates.pop_front();
                check_field("out_year", want.year, o_out_year);
                check_field("out_month", want.month, o_out_month);
                check_field("out_day", want.day, o_out_day);
                check_field("out_weekday", want.weekday, o_out_weekday);
                check_field("leap_flag", want.leap, o_leap_flag);
                check_field("range_end", want.range_end, o_range_end);
            end
        end
    end

    // ---- receiver back-pressure ----
    initial begin
        int  stall_left;
        int  phase_left;
        bit  calm;
        stall_left = 0;
        phase_left = 0;
        calm       = 1'b0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (phase_left == 0) begin
                calm       = ($urandom_range(0, 3) == 0);
                phase_left = $urandom_range(50, 200);
            end else begin
                phase_left--;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 99) < 25) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 2);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ---- watchdog: idle cycles on all three channels ----
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("[calendar_day_counter] ERROR");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_restart      = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_START_YEAR;
        i_cfg_data     = 14'd0;
        mismatch_count = 0;
        sender_calm    = 1'b0;
        cal_year       = BASE_YEAR;
        cal_month      = MONTH_JAN;
        cal_day        = DAY_FIRST;
        cal_weekday    = BASE_WEEKDAY;
        cfg_start      = 12'(BASE_YEAR);
        cfg_last       = BASE_YEAR;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_date();
        test_start_year_clamp();
        test_last_year_extremes();
        test_drain_pause();
        test_year_end_2100();
        test_leap_year_span();
        test_random_configs();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_dates.size() == 0) begin
            $display("[calendar_day_counter] OK");
        end else begin
            $display("[calendar_day_counter] ERROR");
        end
        $finish;
    end

endmodule
